/* sv/cms_pkg.sv */
// Shared constants and types for the count-min sketch.
`default_nettype none

package cms_pkg;

    localparam int KeyW     = 32;
    localparam int SeedW    = 32;
    localparam int CntW     = 31;
    localparam int CfgIdxW  = 8;
    localparam int NumSeeds = 4;
    localparam int QueueDepth = 4;

    localparam int DefRows    = 4;
    localparam int DefColumns = 1024;

    localparam logic [KeyW-1:0] HashMul = 32'h9E37_79B1;
    localparam logic [CntW-1:0] CntMax  = 31'h7FFF_FFFF;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] SEED_ROW0 = 8'd0;
    localparam logic [CfgIdxW-1:0] SEED_ROW1 = 8'd1;
    localparam logic [CfgIdxW-1:0] SEED_ROW2 = 8'd2;
    localparam logic [CfgIdxW-1:0] SEED_ROW3 = 8'd3;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_QUERY  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_back_state;

endpackage

`default_nettype wire

/* sv/count_min_sketch.sv */
// Top level of the count-min sketch.
`default_nettype none

// Count-min sketch with ROWS banks of 2^B saturating 31-bit counters, where
// B = floor(log2(COLUMNS)); only the first 2^B columns of each row are used.
// Row r is addressed by the top B bits of ((key ^ seed) * 0x9E3779B1) mod
// 2^32, with row r taking seed register r mod 4. An insert item (func 0)
// adds amount to the addressed counter in every row, holding at 2^31-1, and
// yields no result; a query item (func 1) yields one result, the minimum of
// the addressed counters. After reset a clearing pass zeroes all banks in
// parallel, one address per cycle; full stays high during it, while seed
// writes are taken as ever. The front hashes the key in the cycle it is
// accepted and files the item in a four-entry command queue, so pushes
// continue while the back is busy. The back handles each item by reading
// every bank as it pops the item, then writing back the sums or comparing
// the row values, so it takes no new item before it is through with the
// last, since each bank is read and then written for it. Results wait in
// a four-entry result queue; a full result queue stalls the back, and in
// turn the command queue fills and raises full.
module count_min_sketch #(
    parameter int ROWS    = cms_pkg::DefRows,
    parameter int COLUMNS = cms_pkg::DefColumns
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    output logic                               o_full,
    input  wire logic                          i_func,
    input  wire logic [cms_pkg::KeyW-1:0]      i_key,
    input  wire logic [cms_pkg::CntW-1:0]      i_amount,
    output logic                               o_empty,
    input  wire logic                          i_pop,
    output logic      [cms_pkg::CntW-1:0]      o_estimate,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [cms_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire logic [cms_pkg::SeedW-1:0]     i_cfg_data
);
    import cms_pkg::*;

    localparam int ColW = $clog2(COLUMNS + 1) - 1;
    localparam int CmdW = 1 + CntW + ROWS * ColW;

    logic [ROWS-1:0][ColW-1:0] w_cols;
    logic [CmdW-1:0]           w_cmd_in;
    logic [CmdW-1:0]           w_cmd_out;
    logic                      w_cmd_full;
    logic                      w_cmd_empty;
    logic                      w_cmd_pop;
    logic                      w_res_full;
    logic                      w_res_push;
    logic [CntW-1:0]           w_res_data;
    logic                      w_clearing;

    // Seed writes are always taken.
    assign o_cfg_ready = 1'b1;

    cms_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_key       (i_key),
        .o_cols      (w_cols)
    );

    // Command word: operation, amount, one column per row.
    assign w_cmd_in = {i_func, i_amount, w_cols};

    // Hold off new items while the banks are being cleared.
    assign o_full = w_cmd_full || w_clearing;

    cms_fifo #(
        .WIDTH (CmdW),
        .DEPTH (QueueDepth)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !o_full),
        .i_data  (w_cmd_in),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    cms_back #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_empty  (w_cmd_empty),
        .i_cmd_func   (w_cmd_out[CmdW-1]),
        .i_cmd_amount (w_cmd_out[CmdW-2 -: CntW]),
        .i_cmd_cols   (w_cmd_out[ROWS*ColW-1:0]),
        .o_cmd_pop    (w_cmd_pop),
        .i_res_full   (w_res_full),
        .o_res_push   (w_res_push),
        .o_res_data   (w_res_data),
        .o_clearing   (w_clearing)
    );

    cms_fifo #(
        .WIDTH (CntW),
        .DEPTH (QueueDepth)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_data),
        .o_full  (w_res_full),
        .i_pop   (i_pop),
        .o_data  (o_estimate),
        .o_empty (o_empty)
    );

endmodule

`default_nettype wire

/* sv/cms_fifo.sv */
// Small synchronous queue of fixed-width words.
`default_nettype none

module cms_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = cms_pkg::QueueDepth
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);
    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntBits = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   r_mem [DEPTH];
    logic [PtrW-1:0]    r_wr_ptr;
    logic [PtrW-1:0]    r_rd_ptr;
    logic [CntBits-1:0] r_count;
    logic               w_do_push;
    logic               w_do_pop;

    assign o_full    = (r_count == CntBits'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/cms_front.sv */
// Front end: seed registers and per-row hash of the incoming key.
`default_nettype none

module cms_front #(
    parameter int ROWS    = cms_pkg::DefRows,
    parameter int COLUMNS = cms_pkg::DefColumns
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_cfg_wr,
    input  wire logic [cms_pkg::CfgIdxW-1:0]                   i_cfg_index,
    input  wire logic [cms_pkg::SeedW-1:0]                     i_cfg_data,
    input  wire logic [cms_pkg::KeyW-1:0]                      i_key,
    output logic [ROWS-1:0][$clog2(COLUMNS + 1) - 2:0]         o_cols
);
    import cms_pkg::*;

    localparam int ColW = $clog2(COLUMNS + 1) - 1;

    logic [SeedW-1:0] r_seed [NumSeeds];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumSeeds; i++) begin
                r_seed[i] <= SeedW'(i + 1);
            end
        end else if (i_cfg_wr) begin
            unique case (i_cfg_index)
                SEED_ROW0: r_seed[0] <= i_cfg_data;
                SEED_ROW1: r_seed[1] <= i_cfg_data;
                SEED_ROW2: r_seed[2] <= i_cfg_data;
                SEED_ROW3: r_seed[3] <= i_cfg_data;
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    // One multiplier per row; rows beyond four reuse seeds cyclically.
    for (genvar g = 0; g < ROWS; g++) begin : g_lane
        logic [KeyW-1:0] w_prod;
        assign w_prod    = KeyW'((i_key ^ r_seed[g % NumSeeds]) * HashMul);
        assign o_cols[g] = w_prod[KeyW-1 -: ColW];
    end

endmodule

`default_nettype wire

/* sv/cms_back.sv */
// Back end: counter banks, clearing pass, update and minimum search.
`default_nettype none

module cms_back #(
    parameter int ROWS    = cms_pkg::DefRows,
    parameter int COLUMNS = cms_pkg::DefColumns
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_cmd_empty,
    input  wire logic                                          i_cmd_func,
    input  wire logic [cms_pkg::CntW-1:0]                      i_cmd_amount,
    input  wire logic [ROWS-1:0][$clog2(COLUMNS + 1) - 2:0]    i_cmd_cols,
    output logic                                               o_cmd_pop,
    input  wire logic                                          i_res_full,
    output logic                                               o_res_push,
    output logic [cms_pkg::CntW-1:0]                           o_res_data,
    output logic                                               o_clearing
);
    import cms_pkg::*;

    localparam int ColW  = $clog2(COLUMNS + 1) - 1;
    localparam int Depth = 1 << ColW;

    t_back_state              r_state;
    t_back_state              n_state;
    logic [ColW-1:0]          r_clr_addr;
    t_func                    r_func;
    logic [CntW-1:0]          r_amount;
    logic [ROWS-1:0][ColW-1:0] r_cols;
    logic [CntW-1:0]          w_rd_data [ROWS];
    logic                     w_upd_we;
    logic                     w_clr_we;
    logic [CntW-1:0]          w_min;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == ColW'(Depth - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_cmd_empty && !i_res_full) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_clearing = 1'b0;
        w_upd_we   = 1'b0;
        w_clr_we   = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_clearing = 1'b1;
                w_clr_we   = 1'b1;
            end
            ST_IDLE: o_cmd_pop = !i_cmd_empty && !i_res_full;
            ST_EXEC: begin
                w_upd_we   = (r_func == FUNC_INSERT);
                o_res_push = (r_func == FUNC_QUERY);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (w_clr_we) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Latch the command as it leaves the queue.
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_func   <= t_func'(i_cmd_func);
            r_amount <= i_cmd_amount;
            r_cols   <= i_cmd_cols;
        end
    end

    for (genvar g = 0; g < ROWS; g++) begin : g_bank
        logic [CntW-1:0] r_mem [Depth];
        logic [CntW-1:0] r_rd;
        logic [CntW:0]   w_sum;
        logic [CntW-1:0] w_sat;
        logic [ColW-1:0] w_waddr;
        logic [CntW-1:0] w_wdata;

        assign w_sum   = {1'b0, r_rd} + {1'b0, r_amount};
        assign w_sat   = w_sum[CntW] ? CntMax : w_sum[CntW-1:0];
        assign w_waddr = w_clr_we ? r_clr_addr : r_cols[g];
        assign w_wdata = w_clr_we ? '0 : w_sat;

        always_ff @(posedge i_clk) begin
            if (w_clr_we || w_upd_we) begin
                r_mem[w_waddr] <= w_wdata;
            end
            r_rd <= r_mem[i_cmd_cols[g]];
        end

        assign w_rd_data[g] = r_rd;
    end

    always_comb begin
        w_min = CntMax;
        for (int r = 0; r < ROWS; r++) begin
            if (w_rd_data[r] < w_min) begin
                w_min = w_rd_data[r];
            end
        end
    end

    assign o_res_data = w_min;

endmodule

`default_nettype wire

/* verif/tb_count_min_sketch.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the count-min sketch: predicted estimates vs. results.
module tb_count_min_sketch;
    import cms_pkg::*;

    localparam int ROWS           = DefRows;
    localparam int COLUMNS        = DefColumns;
    // Cycles with no handshake on any port before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4 * COLUMNS + 2000;
    // Cycles to let the command queue and the back end empty out after the
    // last estimate; inserts never announce their completion.
    localparam int DRAIN_CYCLES   = 40;
    localparam int KEY_POOL_SIZE  = 16;
    localparam int PRINT_CAP      = 100;
    localparam logic [CfgIdxW-1:0] CFG_IDX_STRAY = SEED_ROW3 + 1'b1;
    localparam logic [CfgIdxW-1:0] CFG_IDX_LAST  = '1;

    // Shadow copy of the sketch: counters, seeds and the estimates still owed.
    class sketch_shadow;
        logic [CntW-1:0]  counters [ROWS*COLUMNS];
        logic [SeedW-1:0] seeds [NumSeeds];
        logic [CntW-1:0]  estimates_due [$];
        int unsigned      col_w;
        int               mismatches;

        function new();
            col_w = 0;
            while (col_w < 31 && (64'd1 << (col_w + 1)) <= COLUMNS)
                col_w++;
            foreach (counters[i])
                counters[i] = '0;
            foreach (seeds[i])
                seeds[i] = SeedW'(i + 1);
            mismatches = 0;
        endfunction

        // Flat counter address of the column that key hits in one row.
        function int unsigned slot(int unsigned row, logic [KeyW-1:0] key);
            logic [31:0] h;
            h = (key ^ seeds[row % NumSeeds]) * HashMul;
            return row * COLUMNS + ((col_w == 0) ? 0 : int'(h >> (32 - col_w)));
        endfunction

        function void set_seed(logic [CfgIdxW-1:0] idx, logic [SeedW-1:0] data);
            // Writes past the last seed register are dropped.
            if (idx <= SEED_ROW3)
                seeds[idx] = data;
        endfunction

        function void note_item(t_func func, logic [KeyW-1:0] key,
                                logic [CntW-1:0] amount);
            int unsigned     idx;
            logic [CntW-1:0] best;
            if (func == FUNC_INSERT) begin
                for (int r = 0; r < ROWS; r++) begin
                    idx = slot(r, key);
                    if (amount > CntMax - counters[idx])
                        counters[idx] = CntMax;
                    else
                        counters[idx] = counters[idx] + amount;
                end
            end else begin
                best = CntMax;
                for (int r = 0; r < ROWS; r++)
                    if (counters[slot(r, key)] < best)
                        best = counters[slot(r, key)];
                estimates_due.push_back(best);
            end
        endfunction

        task report_mismatch(string what);
            if (mismatches < PRINT_CAP)
                $display("%t mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_estimate(logic [CntW-1:0] got);
            logic [CntW-1:0] want;
            if (estimates_due.size() == 0) begin
                report_mismatch($sformatf("estimate %0d with no query waiting", got));
            end else begin
                want = estimates_due.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("estimate %0d, predicted %0d", got, want));
            end
        endtask

        task check_drained();
            if (estimates_due.size() != 0)
                report_mismatch($sformatf("%0d estimates never arrived",
                                          estimates_due.size()));
        endtask

        function int pending();
            return estimates_due.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_push      = 1'b0;
    t_func               i_func      = FUNC_INSERT;
    logic [KeyW-1:0]     i_key       = '0;
    logic [CntW-1:0]     i_amount    = '0;
    logic                i_pop       = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [SeedW-1:0]    i_cfg_data  = '0;
    logic                o_full;
    logic                o_empty;
    logic [CntW-1:0]     o_estimate;
    logic                o_cfg_ready;

    sketch_shadow        shadow = new();
    bit                  calm = 1'b0;   // set for the final stretch: no idling anywhere
    int                  stalled = 0;
    logic [KeyW-1:0]     key_pool [KEY_POOL_SIZE];

    count_min_sketch #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_func      (i_func),
        .i_key       (i_key),
        .i_amount    (i_amount),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_estimate  (o_estimate),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Monitor: sample every handshake at the rising edge, before any of this
    // edge's updates land, and feed the shadow in acceptance order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                shadow.set_seed(i_cfg_index, i_cfg_data);
            if (i_push && !o_full)
                shadow.note_item(i_func, i_key, i_amount);
            if (i_pop && !o_empty)
                shadow.check_estimate(o_estimate);
        end
    end

    // Watchdog: count cycles in which nothing moves on any port.
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty) || (i_cfg_valid && o_cfg_ready)) begin
            stalled <= 0;
        end else if (stalled >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stalled <= stalled + 1;
        end
    end

    // Result side: pop, or on one draw in four stall in a burst of random length.
    initial begin
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                i_pop <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                i_pop <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Offer one item and hold it until the block takes it. Push stays high
    // into the next item unless a gap is drawn, so it is never dropped and
    // raised again within one step.
    task automatic send_item(t_func func, logic [KeyW-1:0] key, logic [CntW-1:0] amount);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_push   <= 1'b1;
        i_func   <= func;
        i_key    <= key;
        i_amount <= amount;
        do @(posedge i_clk); while (o_full);
    endtask

    // Drop push and wait until every owed estimate has come back.
    task automatic hold_until_drained();
        i_push <= 1'b0;
        do @(posedge i_clk); while (shadow.pending() != 0);
    endtask

    // Bring the block to idle before touching the seeds: drain estimates, then
    // give any trailing inserts time to leave the back end.
    task automatic settle();
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all four seeds back to back; optionally slip in writes to
    // indexes past the last seed, which must leave every seed alone.
    task automatic program_seeds(logic [SeedW-1:0] s0, logic [SeedW-1:0] s1,
                                 logic [SeedW-1:0] s2, logic [SeedW-1:0] s3,
                                 bit stray);
        logic [CfgIdxW-1:0] idx_q [$];
        logic [SeedW-1:0]   dat_q [$];
        idx_q = '{SEED_ROW0, SEED_ROW1, SEED_ROW2, SEED_ROW3};
        dat_q = '{s0, s1, s2, s3};
        if (stray) begin
            idx_q.push_front(CFG_IDX_STRAY);
            dat_q.push_front($urandom);
            idx_q.insert(3, CFG_IDX_LAST);
            dat_q.insert(3, $urandom);
        end
        foreach (idx_q[i]) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx_q[i];
            i_cfg_data  <= dat_q[i];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Field extremes, exact fill to the top, and saturation from both sides.
    task automatic directed_items();
        send_item(FUNC_QUERY,  32'h0000_0000, '0);      // untouched counters read zero
        send_item(FUNC_INSERT, 32'h0000_0000, '0);
        send_item(FUNC_QUERY,  32'h0000_0000, CntMax);  // amount ignored on query
        send_item(FUNC_INSERT, 32'hFFFF_FFFF, CntMax);
        send_item(FUNC_QUERY,  32'hFFFF_FFFF, '0);
        send_item(FUNC_INSERT, 32'hFFFF_FFFF, 31'd1);   // already full: hold at max
        send_item(FUNC_QUERY,  32'hFFFF_FFFF, '0);
        send_item(FUNC_INSERT, 32'h0000_0000, 31'd1);
        send_item(FUNC_INSERT, 32'h0000_0000, CntMax);  // carry past max: clamp
        send_item(FUNC_QUERY,  32'h0000_0000, '0);
        send_item(FUNC_INSERT, 32'h5555_5555, 31'h2AAA_AAAA);
        send_item(FUNC_INSERT, 32'hAAAA_AAAA, 31'h5555_5555);
        send_item(FUNC_QUERY,  32'h5555_5555, '0);
        send_item(FUNC_QUERY,  32'hAAAA_AAAA, '0);
        send_item(FUNC_INSERT, 32'h0000_0001, 31'h4000_0000);
        send_item(FUNC_INSERT, 32'h0000_0001, 31'h4000_0000); // sum is 2^31: clamp
        send_item(FUNC_QUERY,  32'h0000_0001, '0);
        send_item(FUNC_INSERT, 32'h0000_0002, CntMax - 31'd5);
        send_item(FUNC_INSERT, 32'h0000_0002, 31'd5);          // lands exactly on max
        send_item(FUNC_QUERY,  32'h0000_0002, '0);
        send_item(FUNC_QUERY,  32'h8000_0000, '0);
    endtask

    // Mostly keys from a small pool so queries hit counters that were built
    // up, plus fully random keys; amounts mostly small, now and then huge
    // so counters climb into saturation over the phase.
    task automatic random_phase(int n, int pressure_at);
        t_func           func;
        logic [KeyW-1:0] key;
        logic [CntW-1:0] amount;
        int              sel;
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 0; i < n; i++) begin
            if (i == pressure_at)
                hold_until_drained();
            key  = ($urandom_range(0, 99) < 80) ? key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)]
                                                : $urandom;
            func = $urandom_range(0, 1) ? FUNC_QUERY : FUNC_INSERT;
            sel  = $urandom_range(0, 99);
            if (sel < 75)
                amount = CntW'($urandom_range(0, 255));
            else if (sel < 95)
                amount = CntW'($urandom_range(0, 1 << 20));
            else
                amount = CntW'($urandom);
            send_item(func, key, amount);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Seed writes go in while the clearing pass still runs.
        program_seeds(32'd1, 32'd2, 32'd3, 32'd4, 1'b1);
        directed_items();
        random_phase(250, -1);

        settle();
        program_seeds('0, '0, '0, '0, 1'b0);
        random_phase(250, 120);   // sender holds off mid-phase until all estimates are in

        settle();
        program_seeds('1, '1, '1, '1, 1'b1);
        random_phase(250, -1);

        settle();
        program_seeds($urandom, $urandom, $urandom, $urandom, 1'b0);
        random_phase(250, -1);

        settle();
        program_seeds($urandom, $urandom, $urandom, $urandom, 1'b1);
        random_phase(250, -1);

        // Final stretch at full speed on both sides.
        settle();
        calm = 1'b1;
        program_seeds($urandom, 32'hFFFF_FFFF, 32'h0000_0000, $urandom, 1'b0);
        random_phase(280, -1);

        settle();
        shadow.check_drained();
        if (shadow.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
